/* src/blpd_pkg.sv */
// shared types, codes and sizes for the bounded list with positional delete
package blpd_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ENTRY_BITS  = 32;

  localparam int ADDR_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W   = 6;
  localparam int CAP_W   = 7;
  localparam int VALUE_W = 32;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PLAY   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] entry_out;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ENTRY_BITS-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

/* src/blpd_store.sv */
// entry memory: one write port and one registered read port
module blpd_store (
  input  logic                            clk,
  input  blpd_pkg::mem_req_t              mem_req,
  output logic [blpd_pkg::ENTRY_BITS-1:0] mem_rdata
);

  logic [blpd_pkg::ENTRY_BITS-1:0] mem [blpd_pkg::MAX_ENTRIES];
  logic [blpd_pkg::ENTRY_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

/* src/blpd_seq.sv */
// request sequencer: count, capacity, index stepping and result generation
module blpd_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  blpd_pkg::in_item_t              in_data,
  input  logic                            cfg_we,
  input  logic [blpd_pkg::CAP_W-1:0]      cfg_data,
  output blpd_pkg::mem_req_t              mem_req,
  input  logic [blpd_pkg::ENTRY_BITS-1:0] mem_rdata,
  output blpd_pkg::emit_t                 emit,
  input  logic                            load_ok
);

  localparam int ADDR_W = blpd_pkg::ADDR_W;
  localparam int CNT_W  = blpd_pkg::CNT_W;
  localparam int CMP_W  = blpd_pkg::CMP_W;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_REM_HEAD = 5'b00010,
    S_SHIFT    = 5'b00100,
    S_PLAY     = 5'b01000,
    S_EMIT     = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [blpd_pkg::CAP_W-1:0]    cap_r, cap_nxt;
  logic [ADDR_W-1:0]             idx_r, idx_nxt;
  logic [CNT_W-1:0]              left_r, left_nxt;
  blpd_pkg::out_item_t           res_r, res_nxt;

  logic                          accept;
  logic [CNT_W-1:0]              cap_eff;
  logic [CNT_W-1:0]              idx_inc;
  logic                          more;
  logic [ADDR_W-1:0]             wrap_idx;

  // effective capacity: zero acts as one, clamp to the store depth
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > blpd_pkg::MAX_ENTRIES) begin
      cap_eff = CNT_W'(blpd_pkg::MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // shared index step: next index and its compare against the count
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign more     = idx_inc < count_r;
  assign wrap_idx = more ? ADDR_W'(idx_inc) : '0;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cap_nxt   = cap_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    res_nxt   = res_r;
    mem_req   = '0;
    emit      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            blpd_pkg::REQ_APPEND: begin
              if (count_r >= cap_eff) begin
                res_nxt = '{status: blpd_pkg::ST_FULL, entry_out: '0, last_result: 1'b1};
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(count_r);
                mem_req.wdata = blpd_pkg::ENTRY_BITS'(in_data.entry_value);
                count_nxt     = count_r + CNT_W'(1);
                res_nxt = '{status: blpd_pkg::ST_OK, entry_out: '0, last_result: 1'b1};
              end
              state_nxt = S_EMIT;
            end
            blpd_pkg::REQ_REMOVE, blpd_pkg::REQ_PLAY: begin
              if (count_r == '0) begin
                res_nxt   = '{status: blpd_pkg::ST_EMPTY, entry_out: '0, last_result: 1'b1};
                state_nxt = S_EMIT;
              end else if (CMP_W'(in_data.position) >= CMP_W'(count_r)) begin
                res_nxt   = '{status: blpd_pkg::ST_BAD_POS, entry_out: '0, last_result: 1'b1};
                state_nxt = S_EMIT;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(in_data.position);
                idx_nxt       = ADDR_W'(in_data.position);
                left_nxt      = count_r;
                state_nxt     = (in_data.req_type == blpd_pkg::REQ_REMOVE) ? S_REM_HEAD : S_PLAY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_REM_HEAD, S_SHIFT: begin
        if (state_r == S_REM_HEAD) begin
          res_nxt = '{status: blpd_pkg::ST_OK,
                      entry_out: blpd_pkg::VALUE_W'(mem_rdata),
                      last_result: 1'b1};
        end else begin
          // move the entry just read down one place
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_r - ADDR_W'(1);
          mem_req.wdata = mem_rdata;
        end
        if (more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(idx_inc);
          idx_nxt       = ADDR_W'(idx_inc);
          state_nxt     = S_SHIFT;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_EMIT;
        end
      end

      S_PLAY: begin
        emit.valid = 1'b1;
        emit.item  = '{status: blpd_pkg::ST_OK,
                       entry_out: blpd_pkg::VALUE_W'(mem_rdata),
                       last_result: (left_r == CNT_W'(1))};
        if (load_ok) begin
          if (left_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            left_nxt      = left_r - CNT_W'(1);
            mem_req.re    = 1'b1;
            mem_req.raddr = wrap_idx;
            idx_nxt       = wrap_idx;
          end
        end
      end

      S_EMIT: begin
        emit.valid = 1'b1;
        emit.item  = res_r;
        if (load_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      cap_nxt   = cfg_data;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cap_r   <= blpd_pkg::CAP_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    res_r  <= res_nxt;
  end

endmodule

/* src/bounded_list_with_positional_delete_unit.sv */
// top level of the bounded list with positional delete
//
// usage:
//   input channel (in_valid / in_stall / in_data) carries one request
//   transaction: append, remove at position, or play from position.
//   result channel (out_valid / out_stall / out_data) carries result
//   transactions; the final result of a request has last_result set.
//   cfg_we / cfg_data write the list capacity; any write empties the list.
// timing:
//   append and error requests: one result, offered in S_EMIT to the output register.
//   remove: the entry store is walked one slot per cycle to close the gap,
//   as the store has a single read and a single write port; the result then
//   goes through S_EMIT to the output register.
//   play: first result from the given position, then one per cycle with no gap
//   while the output register takes each one, count results in all.
//   one request is worked at a time; in_stall is high until the last result
//   is loaded into the output register.
// reset: synchronous, active low; list empty, capacity 64, no result pending.
// stall: a stalled result holds in the output register and the sequencer
//   waits, so no result is dropped or repeated.
module bounded_list_with_positional_delete_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  blpd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output blpd_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [blpd_pkg::CAP_W-1:0]    cfg_data
);

  blpd_pkg::mem_req_t              mem_req;
  logic [blpd_pkg::ENTRY_BITS-1:0] mem_rdata;
  blpd_pkg::emit_t                 emit;
  logic                            load_ok;

  logic                            out_valid_r;
  blpd_pkg::out_item_t             out_data_r;

  // output register is free when empty or being drained this cycle
  assign load_ok = !out_valid_r || !out_stall;

  blpd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .emit      (emit),
    .load_ok   (load_ok)
  );

  blpd_store u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid && load_ok) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload only moves when a new result is loaded
  always_ff @(posedge clk) begin
    if (emit.valid && load_ok) begin
      out_data_r <= emit.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
